>>> rtl/rdfs_pkg.sv
// Shared types and constants of the receive descriptor ring frame scanner.
// Holds the descriptor word, command and status structs and the controller states.
// No dependencies; the controller, datapath, top and testbench import this package.
`default_nettype none

package rdfs_pkg;

    localparam int RING_DEPTH_DEF = 32;
    // The slot and hardware index fields are 5 bits wide, so at most 32 entries are used.
    localparam int SLOT_LIMIT = 32;
    localparam logic [5:0] RING_SIZE_RST = 6'd32;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_SCAN = 1'b1;

    typedef struct packed {
        logic        owned;
        logic        err;
        logic        sum_err;
        logic        first;
        logic        last;
        logic [13:0] len;
    } t_desc;

    typedef struct packed {
        logic [4:0] slot;
        t_desc      desc;
        logic [4:0] hw_index;
    } t_in_beat;

    typedef enum logic [2:0] {
        KIND_EMPTY     = 3'd0,
        KIND_SKIPPED   = 3'd1,
        KIND_BAD_FIRST = 3'd2,
        KIND_NO_LAST   = 3'd3,
        KIND_SPAN_ERR  = 3'd4,
        KIND_DELIVERED = 3'd5
    } t_kind;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_START,
        CMD_NORM,
        CMD_EMPTY,
        CMD_SKIP,
        CMD_DROP,
        CMD_BEGIN,
        CMD_STEP,
        CMD_NOLAST,
        CMD_FRAME
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_NORM,
        ST_HEAD,
        ST_SEARCH
    } t_state;

    typedef struct packed {
        logic norm_done;
        logic rp_eq_hw;
        logic d_own;
        logic d_bad;
        logic d_last;
        logic idx_next_hw;
        logic rp_next_hw;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

>>> rtl/rdfs_intf.sv
// Valid/ready channel interfaces of the frame scanner: input items, results, configuration.
// Stand-alone; field names follow the block's item and result fields.
`default_nettype none

interface rdfs_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [4:0]  slot;
    logic        dma_owned;
    logic        desc_error;
    logic        summary_error;
    logic        first_flag;
    logic        last_flag;
    logic [13:0] length_field;
    logic [4:0]  hw_index;

    modport source (
        output valid, op, slot, dma_owned, desc_error, summary_error,
               first_flag, last_flag, length_field, hw_index,
        input  ready
    );
    modport sink (
        input  valid, op, slot, dma_owned, desc_error, summary_error,
               first_flag, last_flag, length_field, hw_index,
        output ready
    );
endinterface

interface rdfs_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [4:0]  start_slot;
    logic [5:0]  desc_count;
    logic [13:0] frame_bytes;
    logic        final_res;

    modport source (
        output valid, kind, start_slot, desc_count, frame_bytes, final_res,
        input  ready
    );
    modport sink (
        input  valid, kind, start_slot, desc_count, frame_bytes, final_res,
        output ready
    );
endinterface

interface rdfs_cfg_if;
    logic       valid;
    logic       ready;
    logic [5:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

>>> rtl/rdfs_ctrl.sv
// Controller of the frame scanner: sequences loads, index normalization and the ring walk.
// Depends on rdfs_pkg; drives commands into rdfs_datapath and reads back its status.
`default_nettype none

module rdfs_ctrl
    import rdfs_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_in_op,
    input  wire t_status i_status,
    output logic         o_in_ready,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = CMD_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_op == OP_LOAD) begin
                        o_cmd = CMD_LOAD;
                    end else begin
                        o_cmd   = CMD_START;
                        n_state = ST_NORM;
                    end
                end
            end
            ST_NORM: begin
                if (!i_status.norm_done) begin
                    o_cmd = CMD_NORM;
                end else if (!i_status.rp_eq_hw) begin
                    n_state = ST_HEAD;
                end else if (i_status.out_free) begin
                    o_cmd   = CMD_EMPTY;
                    n_state = ST_IDLE;
                end
            end
            ST_HEAD: begin
                // A skip or drop result waits here until the output register can take it.
                if (i_status.d_own || i_status.d_bad) begin
                    if (i_status.out_free) begin
                        o_cmd   = i_status.d_own ? CMD_SKIP : CMD_DROP;
                        n_state = i_status.rp_next_hw ? ST_IDLE : ST_HEAD;
                    end
                end else begin
                    o_cmd   = CMD_BEGIN;
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (i_status.d_last) begin
                    if (i_status.out_free) begin
                        o_cmd   = CMD_FRAME;
                        n_state = i_status.idx_next_hw ? ST_IDLE : ST_HEAD;
                    end
                end else if (i_status.idx_next_hw) begin
                    if (i_status.out_free) begin
                        o_cmd   = CMD_NOLAST;
                        n_state = i_status.rp_next_hw ? ST_IDLE : ST_HEAD;
                    end
                end else begin
                    o_cmd = CMD_STEP;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/rdfs_datapath.sv
// Datapath of the frame scanner: descriptor status memory with valid bits, read pointer,
// walk cursor, span accumulators, ring size register and the result register.
// Depends on rdfs_pkg and the channel interfaces; commanded by rdfs_ctrl.
`default_nettype none

module rdfs_datapath
    import rdfs_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cmd     i_cmd,
    input  wire t_in_beat i_in,
    rdfs_cfg_if.sink      i_cfg,
    rdfs_out_if.source    o_out,
    output t_status       o_status
);

    localparam int CAP = (RING_DEPTH < SLOT_LIMIT) ? RING_DEPTH : SLOT_LIMIT;
    localparam int IW  = $clog2(CAP);
    localparam logic [5:0] CAP6 = 6'(CAP);

    // An entry whose valid bit is clear reads as handed back to the DMA.
    t_desc            mem [CAP];
    logic [CAP-1:0]   r_valid;
    logic [CAP-1:0]   n_valid;
    t_desc            r_rd;
    logic             r_rd_v;

    logic [5:0]       r_ring_size;
    logic [IW-1:0]    r_rp;
    logic [IW-1:0]    n_rp;
    logic [4:0]       r_hw;
    logic [4:0]       n_hw;
    logic [IW-1:0]    r_idx;
    logic [IW-1:0]    n_idx;
    logic [CAP-1:0]   r_pend;
    logic [CAP-1:0]   n_pend;
    logic             r_acc;
    logic             n_acc;
    logic [5:0]       r_cnt;
    logic [5:0]       n_cnt;

    logic             r_out_valid;
    t_kind            r_out_kind;
    logic [4:0]       r_out_start;
    logic [5:0]       r_out_count;
    logic [13:0]      r_out_bytes;
    logic             r_out_final;

    logic [5:0]       ring_n;
    logic [5:0]       rp_w;
    logic [5:0]       hw_w;
    logic [5:0]       rp_sum;
    logic [5:0]       idx_sum;
    logic [IW-1:0]    rp_inc;
    logic [IW-1:0]    idx_inc;
    logic             rp_ge;
    logic             hw_ge;
    logic             cur_own;
    logic             cur_err;
    logic             cur_first;
    logic             cur_last;
    logic [13:0]      cur_len;
    logic             wr_en;
    logic             out_free;
    logic             emit;
    t_kind            e_kind;
    logic [5:0]       e_count;
    logic [13:0]      e_bytes;
    logic             e_final;
    logic             frame_bad;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_size <= RING_SIZE_RST;
        end else if (i_cfg.valid) begin
            r_ring_size <= i_cfg.data;
        end
    end

    // Ring in use: the register clamped to one at the bottom and to the storage at the top.
    always_comb begin
        if (r_ring_size == 6'd0) begin
            ring_n = 6'd1;
        end else if (r_ring_size > CAP6) begin
            ring_n = CAP6;
        end else begin
            ring_n = r_ring_size;
        end
    end

    assign rp_w    = 6'(r_rp);
    assign hw_w    = 6'(r_hw);
    assign rp_ge   = (rp_w >= ring_n);
    assign hw_ge   = (hw_w >= ring_n);
    assign rp_sum  = rp_w + 6'd1;
    assign idx_sum = 6'(r_idx) + 6'd1;
    assign rp_inc  = (rp_sum == ring_n) ? '0 : rp_sum[IW-1:0];
    assign idx_inc = (idx_sum == ring_n) ? '0 : idx_sum[IW-1:0];

    assign cur_own   = !r_rd_v || r_rd.owned;
    assign cur_err   = r_rd_v && (r_rd.err || r_rd.sum_err);
    assign cur_first = r_rd_v && r_rd.first;
    assign cur_last  = r_rd_v && r_rd.last;
    assign cur_len   = r_rd_v ? r_rd.len : 14'd0;
    assign frame_bad = r_acc || cur_err;
    assign out_free  = !r_out_valid || o_out.ready;
    assign wr_en     = (i_cmd == CMD_LOAD) && ({1'b0, i_in.slot} < CAP6);

    always_comb begin
        n_valid = r_valid;
        n_rp    = r_rp;
        n_hw    = r_hw;
        n_idx   = r_idx;
        n_pend  = r_pend;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        emit    = 1'b0;
        e_kind  = KIND_EMPTY;
        e_count = 6'd0;
        e_bytes = 14'd0;
        e_final = 1'b0;
        case (i_cmd)
            CMD_LOAD: begin
                if (wr_en) begin
                    n_valid[i_in.slot[IW-1:0]] = 1'b1;
                end
            end
            CMD_START: begin
                n_hw  = i_in.hw_index;
                n_idx = r_rp;
            end
            CMD_NORM: begin
                // One subtraction per cycle brings both indexes below the ring size.
                if (rp_ge) begin
                    n_rp = IW'(rp_w - ring_n);
                end
                if (hw_ge) begin
                    n_hw = 5'(hw_w - ring_n);
                end
                n_idx = n_rp;
            end
            CMD_EMPTY: begin
                emit    = 1'b1;
                e_final = 1'b1;
            end
            CMD_SKIP: begin
                emit    = 1'b1;
                e_kind  = KIND_SKIPPED;
                e_count = 6'd1;
                e_final = o_status.rp_next_hw;
                n_rp    = rp_inc;
                n_idx   = rp_inc;
            end
            CMD_DROP: begin
                emit          = 1'b1;
                e_kind        = KIND_BAD_FIRST;
                e_count       = 6'd1;
                e_final       = o_status.rp_next_hw;
                n_valid[r_rp] = 1'b0;
                n_rp          = rp_inc;
                n_idx         = rp_inc;
            end
            CMD_BEGIN: begin
                n_pend = '0;
                n_acc  = 1'b0;
                n_cnt  = 6'd0;
            end
            CMD_STEP: begin
                n_pend[r_idx] = 1'b1;
                n_acc         = frame_bad;
                n_cnt         = r_cnt + 6'd1;
                n_idx         = idx_inc;
            end
            CMD_NOLAST: begin
                emit          = 1'b1;
                e_kind        = KIND_NO_LAST;
                e_count       = 6'd1;
                e_final       = o_status.rp_next_hw;
                n_valid[r_rp] = 1'b0;
                n_rp          = rp_inc;
                n_idx         = rp_inc;
            end
            CMD_FRAME: begin
                emit           = 1'b1;
                e_kind         = frame_bad ? KIND_SPAN_ERR : KIND_DELIVERED;
                e_count        = r_cnt + 6'd1;
                e_bytes        = frame_bad ? 14'd0 : cur_len;
                e_final        = o_status.idx_next_hw;
                n_valid        = r_valid & ~r_pend;
                n_valid[r_idx] = 1'b0;
                n_rp           = idx_inc;
                n_idx          = idx_inc;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[i_in.slot[IW-1:0]] <= i_in.desc;
        end
        // The read tracks the next cursor, so data for the cursor is registered together with it.
        r_rd <= mem[n_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_v  <= 1'b0;
            r_rp    <= '0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_rd_v  <= n_valid[n_idx];
            r_rp    <= n_rp;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hw   <= n_hw;
        r_pend <= n_pend;
        r_acc  <= n_acc;
        r_cnt  <= n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_kind  <= e_kind;
            r_out_start <= 5'(r_rp);
            r_out_count <= e_count;
            r_out_bytes <= e_bytes;
            r_out_final <= e_final;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.kind        = r_out_kind;
    assign o_out.start_slot  = r_out_start;
    assign o_out.desc_count  = r_out_count;
    assign o_out.frame_bytes = r_out_bytes;
    assign o_out.final_res   = r_out_final;

    assign o_status.norm_done   = !rp_ge && !hw_ge;
    assign o_status.rp_eq_hw    = (rp_w == hw_w);
    assign o_status.d_own       = cur_own;
    assign o_status.d_bad       = cur_err || !cur_first;
    assign o_status.d_last      = cur_last;
    assign o_status.idx_next_hw = (6'(idx_inc) == hw_w);
    assign o_status.rp_next_hw  = (6'(rp_inc) == hw_w);
    assign o_status.out_free    = out_free;

endmodule

`default_nettype wire

>>> rtl/rx_descriptor_ring_frame_scanner_top.sv
// Receive descriptor ring frame scanner: a load item writes one descriptor status word,
// a scan item walks the ring from the read pointer up to the given hardware index and gives
// one result per skipped, dropped or delivered descriptor group, the last one marked final,
// or a single final empty result when the window is empty. A scan is accepted, then the
// read pointer and hardware index are brought below the ring size in use by repeated
// subtraction of it (none when both are already in range), and then the indexes are checked.
// The status memory has a single read port and the walk reads one entry per cycle while no
// result waits for the output register: a skipped or dropped descriptor is handled at the
// head, a frame is opened at its first descriptor and stepped through to its last one, and
// a first descriptor with no last one in the window is stepped through up to the hardware
// index, after which the walk moves on by a single descriptor. A result that cannot enter
// the output register stalls the walk until it can. Reset marks every entry as handed back
// to the DMA through per-entry valid bits, so no clearing pass is needed. The result
// register lets the next item in while the final result still waits to be taken.
// Depends on rdfs_pkg, the channel interfaces, rdfs_ctrl and rdfs_datapath.
`default_nettype none

module rx_descriptor_ring_frame_scanner_top
    import rdfs_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rdfs_in_if.sink    i_in,
    rdfs_cfg_if.sink   i_cfg,
    rdfs_out_if.source o_out
);

    t_cmd     cmd;
    t_status  status;
    t_in_beat in_beat;
    logic     in_ready;

    assign i_in.ready = in_ready;

    assign in_beat.slot         = i_in.slot;
    assign in_beat.desc.owned   = i_in.dma_owned;
    assign in_beat.desc.err     = i_in.desc_error;
    assign in_beat.desc.sum_err = i_in.summary_error;
    assign in_beat.desc.first   = i_in.first_flag;
    assign in_beat.desc.last    = i_in.last_flag;
    assign in_beat.desc.len     = i_in.length_field;
    assign in_beat.hw_index     = i_in.hw_index;

    rdfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_op    (i_in.op),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    rdfs_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_in     (in_beat),
        .i_cfg    (i_cfg),
        .o_out    (o_out),
        .o_status (status)
    );

endmodule

`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// Testbench of the receive descriptor ring frame scanner: directed and random loads and scans,
// checked field by field against a predictor of the ring walk kept in this file.
// Depends on rdfs_pkg, the channel interfaces and rx_descriptor_ring_frame_scanner_top.

module tb_top;
    import rdfs_pkg::*;

    localparam int ITEM_TARGET     = 170;
    localparam int SETTLE_CYCLES   = 40;
    localparam int HOLD_OFF_CYCLES = 400;

    typedef struct packed {
        logic       op;
        logic [4:0] slot;
        t_desc      desc;
        logic [4:0] hw;
    } t_rx_item;

    typedef struct {
        t_kind       kind;
        logic [4:0]  start_slot;
        logic [5:0]  desc_count;
        logic [13:0] frame_bytes;
        logic        final_res;
    } t_scan_report;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rdfs_in_if  in_ch ();
    rdfs_out_if out_ch ();
    rdfs_cfg_if cfg_ch ();

    rx_descriptor_ring_frame_scanner_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // Predicted state of the ring and the queue of results still to come.
    t_desc        model_desc [32];
    logic [4:0]   model_rd_ptr;
    logic [5:0]   model_ring_size;
    t_scan_report reports_due [$];
    t_scan_report want;

    int  fault_count   = 0;
    int  items_sent    = 0;
    int  scans_seen    = 0;
    int  reports_seen  = 0;
    int  cfg_writes    = 0;
    int  rx_hold_cycles = 0;
    bit  no_idle       = 1'b0;

    function automatic int ring_in_use();
        int n;
        n = model_ring_size;
        if (n == 0) n = 1;
        if (n > 32) n = 32;
        return n;
    endfunction

    function automatic void hand_back(int idx);
        model_desc[idx] = '0;
        model_desc[idx].owned = 1'b1;
    endfunction

    function automatic void reset_model();
        for (int i = 0; i < 32; i++) hand_back(i);
        model_rd_ptr = '0;
        model_ring_size = RING_SIZE_RST;
    endfunction

    function automatic void expect_report(t_kind kind, int start, int count, int bytes, bit fin);
        t_scan_report r;
        r.kind = kind;
        r.start_slot = 5'(start);
        r.desc_count = 6'(count);
        r.frame_bytes = 14'(bytes);
        r.final_res = fin;
        reports_due.push_back(r);
    endfunction

    // Walks the ring from the read pointer up to the hardware index, one report per step.
    function automatic void walk_ring(logic [4:0] hw_in);
        int  n, hw, rp, nxt, window, span, last_idx, idx;
        bit  found, bad;
        n = ring_in_use();
        hw = hw_in % n;
        rp = model_rd_ptr % n;
        if (rp == hw) expect_report(KIND_EMPTY, rp, 0, 0, 1'b1);
        while (rp != hw) begin
            if (model_desc[rp].owned) begin
                nxt = (rp + 1) % n;
                expect_report(KIND_SKIPPED, rp, 1, 0, nxt == hw);
                rp = nxt;
            end else if (model_desc[rp].err || model_desc[rp].sum_err
                         || !model_desc[rp].first) begin
                nxt = (rp + 1) % n;
                expect_report(KIND_BAD_FIRST, rp, 1, 0, nxt == hw);
                hand_back(rp);
                rp = nxt;
            end else begin
                window = (hw + n - rp) % n;
                found = 1'b0;
                last_idx = 0;
                // The search for the closing descriptor ignores who owns it.
                for (int j = 0; j < window; j++) begin
                    idx = (rp + j) % n;
                    if (!found && model_desc[idx].last) begin
                        last_idx = idx;
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    nxt = (rp + 1) % n;
                    expect_report(KIND_NO_LAST, rp, 1, 0, nxt == hw);
                    hand_back(rp);
                    rp = nxt;
                end else begin
                    span = ((last_idx + n - rp) % n) + 1;
                    bad = 1'b0;
                    for (int j = 0; j < span; j++) begin
                        idx = (rp + j) % n;
                        if (model_desc[idx].err || model_desc[idx].sum_err) bad = 1'b1;
                    end
                    nxt = (rp + span) % n;
                    if (bad) expect_report(KIND_SPAN_ERR, rp, span, 0, nxt == hw);
                    else expect_report(KIND_DELIVERED, rp, span, model_desc[last_idx].len,
                                       nxt == hw);
                    for (int j = 0; j < span; j++) hand_back((rp + j) % n);
                    rp = nxt;
                end
            end
        end
        model_rd_ptr = 5'(rp);
    endfunction

    function automatic void check_field(string name, logic [13:0] exp_v, logic [13:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            fault_count++;
        end
    endfunction

    // Every accepted beat is sampled here: configuration, input items and results.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) model_ring_size = cfg_ch.data;
            if (in_ch.valid && in_ch.ready) begin
                if (in_ch.op == OP_SCAN) begin
                    walk_ring(in_ch.hw_index);
                    scans_seen++;
                end else begin
                    model_desc[in_ch.slot].owned   = in_ch.dma_owned;
                    model_desc[in_ch.slot].err     = in_ch.desc_error;
                    model_desc[in_ch.slot].sum_err = in_ch.summary_error;
                    model_desc[in_ch.slot].first   = in_ch.first_flag;
                    model_desc[in_ch.slot].last    = in_ch.last_flag;
                    model_desc[in_ch.slot].len     = in_ch.length_field;
                end
            end
            if (out_ch.valid && out_ch.ready) begin
                reports_seen++;
                if (reports_due.size() == 0) begin
                    $error("unexpected result: kind %0d, start_slot %0d",
                           out_ch.kind, out_ch.start_slot);
                    fault_count++;
                end else begin
                    want = reports_due.pop_front();
                    check_field("kind", want.kind, out_ch.kind);
                    check_field("start_slot", want.start_slot, out_ch.start_slot);
                    check_field("desc_count", want.desc_count, out_ch.desc_count);
                    check_field("frame_bytes", want.frame_bytes, out_ch.frame_bytes);
                    check_field("final_res", want.final_res, out_ch.final_res);
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_len();
        case ($urandom_range(0, 9))
            0: begin
                return 0;
            end
            1: begin
                return 16383;
            end
            default: begin
                return $urandom_range(0, 16383);
            end
        endcase
    endfunction

    // Result side: random stalls, plus a long hold-off when a test asks for one.
    initial begin
        int stall;
        stall = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else if (stall == 0 && !no_idle) begin
                stall = pick_gap();
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                stall--;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    function automatic t_rx_item load_item(int slot, bit own, bit err, bit sum, bit first,
                                           bit last, int len);
        t_rx_item it;
        it = t_rx_item'($bits(t_rx_item)'($urandom));
        it.op = OP_LOAD;
        it.slot = 5'(slot);
        it.desc.owned = own;
        it.desc.err = err;
        it.desc.sum_err = sum;
        it.desc.first = first;
        it.desc.last = last;
        it.desc.len = 14'(len);
        return it;
    endfunction

    function automatic t_rx_item scan_item(int hw);
        t_rx_item it;
        it = t_rx_item'($bits(t_rx_item)'($urandom));
        it.op = OP_SCAN;
        it.hw = 5'(hw);
        return it;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken,
    // with valid still high so that a following item can go back to back.
    task automatic send_item(input t_rx_item it);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.op            <= it.op;
        in_ch.slot          <= it.slot;
        in_ch.dma_owned     <= it.desc.owned;
        in_ch.desc_error    <= it.desc.err;
        in_ch.summary_error <= it.desc.sum_err;
        in_ch.first_flag    <= it.desc.first;
        in_ch.last_flag     <= it.desc.last;
        in_ch.length_field  <= it.desc.len;
        in_ch.hw_index      <= it.hw;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic wait_results_drained();
        in_ch.valid <= 1'b0;
        while (reports_due.size() != 0) @(posedge i_clk);
        // A load leaves nothing to wait for, so give the block time to finish it.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_ring_size(input logic [5:0] value);
        wait_results_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        cfg_writes++;
    endtask

    // Loads frames and lone entries ahead of the read pointer, then scans up to their end.
    task automatic send_frame_batch();
        int n, pos, total, used, flen, hw;
        bit keep_last, err, sum;
        n = ring_in_use();
        pos = model_rd_ptr % n;
        if (n == 1) begin
            send_item(scan_item($urandom_range(0, 31)));
            return;
        end
        total = $urandom_range(1, (n - 1 < 12) ? n - 1 : 12);
        used = 0;
        while (used < total) begin
            case ($urandom_range(0, 9))
                0: begin
                    send_item(load_item((pos + used) % n, 1'b1, $urandom_range(0, 1),
                                        $urandom_range(0, 1), $urandom_range(0, 1),
                                        $urandom_range(0, 1), pick_len()));
                    used++;
                end
                1: begin
                    err = $urandom_range(0, 1);
                    sum = $urandom_range(0, 1);
                    send_item(load_item((pos + used) % n, 1'b0, err, sum,
                                        (err || sum) ? $urandom_range(0, 1) : 0,
                                        $urandom_range(0, 1), pick_len()));
                    used++;
                end
                default: begin
                    flen = $urandom_range(1, 4);
                    if (flen > total - used) flen = total - used;
                    keep_last = ($urandom_range(0, 9) != 0);
                    for (int j = 0; j < flen; j++) begin
                        send_item(load_item((pos + used + j) % n,
                                            j > 0 && $urandom_range(0, 9) == 0,
                                            $urandom_range(0, 19) == 0,
                                            $urandom_range(0, 19) == 0,
                                            j == 0, keep_last && j == flen - 1, pick_len()));
                    end
                    used += flen;
                end
            endcase
        end
        // Point at the same slot through an index above the ring now and then.
        hw = (pos + total) % n;
        hw = hw + n * $urandom_range(0, (31 - hw) / n);
        send_item(scan_item(hw));
    endtask

    task automatic send_noise_item();
        send_item(t_rx_item'($bits(t_rx_item)'($urandom)));
    endtask

    task automatic test_directed();
        send_item(scan_item(0));
        send_item(scan_item(3));
        // A three descriptor frame followed by an entry still owned by the DMA.
        send_item(load_item(3, 0, 0, 0, 1, 0, 100));
        send_item(load_item(4, 0, 0, 0, 0, 0, 5));
        send_item(load_item(5, 0, 0, 0, 0, 1, 16383));
        send_item(scan_item(7));
        send_item(load_item(7, 0, 1, 0, 1, 0, 9));
        send_item(load_item(8, 0, 0, 0, 0, 1, 9));
        send_item(load_item(9, 0, 0, 1, 1, 0, 9));
        send_item(load_item(10, 0, 0, 0, 1, 0, 1));
        send_item(load_item(11, 1, 0, 0, 0, 1, 77));
        send_item(load_item(12, 0, 0, 0, 1, 0, 2));
        send_item(load_item(13, 0, 0, 1, 0, 1, 3));
        send_item(load_item(14, 0, 0, 0, 1, 0, 4));
        send_item(scan_item(15));
        // Wrap from the middle of the ring past the top slot to index zero.
        send_item(load_item(31, 0, 0, 0, 1, 1, 0));
        send_item(scan_item(0));
        send_item(load_item(0, 0, 0, 0, 1, 0, 1));
        send_item(load_item(1, 0, 1, 0, 0, 1, 8191));
        send_item(scan_item(2));
    endtask

    task automatic test_ring_sizes();
        logic [5:0] sizes [8];
        sizes = '{6'd0, 6'd1, 6'd63, 6'd33, 6'd2, 6'd5, 6'd17, 6'd32};
        foreach (sizes[i]) begin
            write_ring_size(sizes[i]);
            send_frame_batch();
            send_noise_item();
            send_frame_batch();
        end
    endtask

    task automatic test_random_traffic();
        write_ring_size(6'($urandom_range(3, 32)));
        while (items_sent < ITEM_TARGET) begin
            no_idle = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 99) < 15) send_noise_item();
            else send_frame_batch();
            if ($urandom_range(0, 19) == 0) write_ring_size(6'($urandom_range(1, 32)));
        end
        no_idle = 1'b0;
    endtask

    // Results stop for a long while; near-full ring walks fill the block and stall input.
    task automatic test_receiver_holdoff();
        int n;
        write_ring_size(RING_SIZE_RST);
        no_idle = 1'b1;
        rx_hold_cycles = HOLD_OFF_CYCLES;
        for (int k = 0; k < 6; k++) begin
            n = ring_in_use();
            send_item(scan_item((model_rd_ptr % n + n - 1) % n));
            send_item(load_item($urandom_range(0, 31), 0, 0, 0, 1, 1, pick_len()));
        end
        no_idle = 1'b0;
        wait_results_drained();
    endtask

    initial begin
        int guard;
        in_ch.valid = 1'b0;
        in_ch.op = OP_LOAD;
        in_ch.slot = '0;
        in_ch.dma_owned = 1'b0;
        in_ch.desc_error = 1'b0;
        in_ch.summary_error = 1'b0;
        in_ch.first_flag = 1'b0;
        in_ch.last_flag = 1'b0;
        in_ch.length_field = '0;
        in_ch.hw_index = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        i_rst_n = 1'b0;
        reset_model();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_ring_sizes();
        test_random_traffic();
        test_receiver_holdoff();

        in_ch.valid <= 1'b0;
        guard = 0;
        while (reports_due.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        if (reports_due.size() != 0) begin
            $error("%0d expected results never arrived", reports_due.size());
            fault_count++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d items (%0d scans) and checked %0d results over %0d ring size writes.",
                 items_sent, scans_seen, reports_seen, cfg_writes);
        $display("Ring sizes from one entry to the full ring, with a %0d cycle result hold-off.",
                 HOLD_OFF_CYCLES);
        if (fault_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #15_000_000;
        $display("Run did not complete in time.");
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> rx_descriptor_ring_frame_scanner_top.f
rtl/rdfs_pkg.sv
rtl/rdfs_intf.sv
rtl/rdfs_ctrl.sv
rtl/rdfs_datapath.sv
rtl/rx_descriptor_ring_frame_scanner_top.sv
bench/tb_top.sv
